FILE: hdl/sfbd_pkg.sv
// shared types and constants of the spectral flux beat detector
`timescale 1ns / 1ps
package sfbd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int THR_W       = 20;
    localparam int BCNT_W      = 10;
    localparam int MULT_W      = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_BUCKET_COUNT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_MULT = 8'd1;

    localparam logic [BCNT_W-1:0] BUCKET_COUNT_RST = 10'd64;
    localparam logic [MULT_W-1:0] DEFAULT_MULT_RST = 8'd24;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_FLUX_GO,
        S_FLUX_WAIT,
        S_WALK,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_BEAT_GO,
        S_BEAT_WAIT,
        S_NORM_GO,
        S_NORM_WAIT,
        S_THRESH,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        DIV_FLUX,
        DIV_MEAN,
        DIV_BEAT,
        DIV_NORM
    } div_op_t;

    typedef struct packed {
        logic    capture;
        logic    accumulate;
        logic    div_start;
        div_op_t div_op;
        logic    walk_clear;
        logic    walk;
        logic    thresh;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        logic frame_result;
        logic div_done;
        logic walk_done;
        logic out_free;
    } status_t;

endpackage

FILE: hdl/sfbd_intf.sv
// stream and configuration channel interfaces
`timescale 1ns / 1ps
interface sfbd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] bucket_value;

    modport source (output valid, output bucket_value, input ready);
    modport sink (input valid, input bucket_value, output ready);
endinterface

interface sfbd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] flux_value;
    logic [19:0] threshold_value;
    logic [15:0] excess_value;
    logic [15:0] beat_strength;
    logic        is_beat;

    modport source (output valid, output flux_value, output threshold_value,
                    output excess_value, output beat_strength, output is_beat,
                    input ready);
    modport sink (input valid, input flux_value, input threshold_value,
                  input excess_value, input beat_strength, input is_beat,
                  output ready);
endinterface

interface sfbd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/spectral_flux_beat_detector.sv
// Spectral flux beat detector top level. Each bucket beat is accepted in S_IDLE, which also
// reads the same bucket of the previous frame from the frame memory; S_ACC then adds the
// rise and writes the new magnitude back. The last bucket of a frame (other than the
// first frame after reset or after a bucket_count write) adds a frame end pass that walks
// the stored history entries (at most HISTORY_DEPTH, one per cycle through the history
// memory) and then runs four quotients in turn on the shared one-bit-per-cycle divider,
// whose dividend width NW is 25 bits at the default sizes. A finished result sits in
// an output register, so buckets keep flowing while it waits; only the next frame end
// waits for it to be taken. Configuration writes are always taken, and a bucket_count
// write restarts the frame. Memories start undefined and need no clearing pass.
`timescale 1ns / 1ps
module spectral_flux_beat_detector #(
    parameter int MAX_BUCKETS   = 512,
    parameter int HISTORY_DEPTH = 100
) (
    input  logic       clk,
    input  logic       rst_n,
    sfbd_in_if.sink    bucket_in,
    sfbd_out_if.source result_out,
    sfbd_cfg_if.sink   cfg
);
    import sfbd_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg.ready = 1'b1;

    sfbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bucket_in.valid),
        .in_ready (bucket_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sfbd_dp #(
        .MAX_BUCKETS   (MAX_BUCKETS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .bucket_value    (bucket_in.bucket_value),
        .cfg_write       (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .out_ready       (result_out.ready),
        .out_valid       (result_out.valid),
        .flux_value      (result_out.flux_value),
        .threshold_value (result_out.threshold_value),
        .excess_value    (result_out.excess_value),
        .beat_strength   (result_out.beat_strength),
        .is_beat         (result_out.is_beat)
    );
endmodule

FILE: hdl/sfbd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sfbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/sfbd_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sfbd_div #(
    parameter int NW  = 26,
    parameter int DVW = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [NW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic [NW-1:0]  quotient,
    output logic           done
);
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    quo_reg, quo_next;
    logic [DVW-1:0]   rem_reg, rem_next;
    logic [DVW-1:0]   den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVW:0]     trial;

    assign trial = {rem_reg, quo_reg[NW-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DVW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

FILE: hdl/sfbd_ctrl.sv
// frame and frame end sequencer
`timescale 1ns / 1ps
module sfbd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sfbd_pkg::status_t status,
    output sfbd_pkg::cmd_t    cmd
);
    import sfbd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (status.frame_result)
                begin
                    state_next = S_FLUX_GO;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FLUX_GO:   state_next = S_FLUX_WAIT;
            S_FLUX_WAIT: if (status.div_done) state_next = S_WALK;
            S_WALK:      if (status.walk_done) state_next = S_MEAN_GO;
            S_MEAN_GO:   state_next = S_MEAN_WAIT;
            S_MEAN_WAIT: if (status.div_done) state_next = S_BEAT_GO;
            S_BEAT_GO:   state_next = S_BEAT_WAIT;
            S_BEAT_WAIT: if (status.div_done) state_next = S_NORM_GO;
            S_NORM_GO:   state_next = S_NORM_WAIT;
            S_NORM_WAIT: if (status.div_done) state_next = S_THRESH;
            S_THRESH:    state_next = S_FINISH;
            S_FINISH:    if (status.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_ACC:
            begin
                cmd.accumulate = 1'b1;
            end
            S_FLUX_GO:
            begin
                cmd.div_start  = 1'b1;
                cmd.div_op     = DIV_FLUX;
                cmd.walk_clear = 1'b1;
            end
            S_FLUX_WAIT: cmd.div_op = DIV_FLUX;
            S_WALK:      cmd.walk = 1'b1;
            S_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_MEAN;
            end
            S_MEAN_WAIT: cmd.div_op = DIV_MEAN;
            S_BEAT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_BEAT;
            end
            S_BEAT_WAIT: cmd.div_op = DIV_BEAT;
            S_NORM_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_NORM;
            end
            S_NORM_WAIT: cmd.div_op = DIV_NORM;
            S_THRESH:    cmd.thresh = 1'b1;
            S_FINISH:    cmd.finish = status.out_free;
            default:     cmd = '0;
        endcase
    end
endmodule

FILE: hdl/sfbd_dp.sv
// flux accumulation, history walk, threshold and result register
`timescale 1ns / 1ps
module sfbd_dp #(
    parameter int MAX_BUCKETS   = 512,
    parameter int HISTORY_DEPTH = 100
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sfbd_pkg::cmd_t                      cmd,
    output sfbd_pkg::status_t                   status,
    input  logic [sfbd_pkg::SAMPLE_BITS-1:0]    bucket_value,
    input  logic                                cfg_write,
    input  logic [sfbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sfbd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [sfbd_pkg::SAMPLE_BITS-1:0]    flux_value,
    output logic [sfbd_pkg::THR_W-1:0]          threshold_value,
    output logic [sfbd_pkg::SAMPLE_BITS-1:0]    excess_value,
    output logic [sfbd_pkg::SAMPLE_BITS-1:0]    beat_strength,
    output logic                                is_beat
);
    import sfbd_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int IW   = $clog2(MAX_BUCKETS);
    localparam int CW   = $clog2(MAX_BUCKETS + 1);
    localparam int HAW  = $clog2(HISTORY_DEPTH);
    localparam int HCW  = $clog2(HISTORY_DEPTH + 1);
    localparam int RSW  = IW + SB;
    localparam int TSW  = HAW + SB;
    localparam int NW   = (RSW > TSW) ? RSW : TSW;
    localparam int DVW  = (CW > HCW) ? CW : HCW;
    localparam int CMPW = (CW > BCNT_W) ? CW : BCNT_W;
    localparam int HW   = SB + THR_W;

    // configuration
    logic [BCNT_W-1:0] bucket_count_reg;
    logic [MULT_W-1:0] mult_reg;

    // frame state
    logic [IW-1:0]  bucket_index_reg;
    logic [RSW-1:0] rise_sum_reg;
    logic           prev_valid_reg;
    logic [SB-1:0]  sample_reg;

    // history state
    logic [HAW-1:0] ptr_reg;
    logic [HCW-1:0] fill_reg;
    logic [SB-1:0]  last_beat_reg;

    // walk state
    logic [HCW-1:0] walk_k_reg;
    logic           walk_rdv_reg;
    logic [NW-1:0]  total_reg, beat_sum_reg, normal_sum_reg;
    logic [HCW-1:0] beats_reg, normals_reg;

    // frame end results
    logic [SB-1:0]    flux_reg, mean_reg, beat_avg_reg, normal_avg_reg;
    logic [THR_W-1:0] thr_reg;

    logic             out_valid_reg;

    logic [CMPW-1:0]  bc_ext;
    logic [CW-1:0]    count;
    logic             last;
    logic [SB-1:0]    prev_rdata;
    logic [HW-1:0]    hist_rdata;
    logic [SB-1:0]    hist_flux;
    logic [THR_W-1:0] hist_thr;
    logic [NW-1:0]    div_dividend;
    logic [DVW-1:0]   div_divisor;
    logic [NW-1:0]    div_quotient;
    logic             div_done;
    logic             use_mid;
    logic [SB:0]      mid_sum;
    logic [SB+MULT_W-1:0] product;
    logic [THR_W-1:0] thr_calc;
    logic [SB-1:0]    excess;
    logic [SB-1:0]    beat;

    // 0 acts as one bucket, anything past the memory as a full frame
    assign bc_ext = CMPW'(bucket_count_reg);
    always_comb
    begin
        if (bucket_count_reg == '0)
        begin
            count = CW'(1);
        end
        else if (bc_ext > CMPW'(MAX_BUCKETS))
        begin
            count = CW'(MAX_BUCKETS);
        end
        else
        begin
            count = CW'(bc_ext);
        end
    end

    assign last = (CW'(bucket_index_reg) + CW'(1)) >= count;

    sfbd_ram #(.WIDTH(SB), .DEPTH(MAX_BUCKETS)) u_prev_ram (
        .clk   (clk),
        .we    (cmd.accumulate),
        .waddr (bucket_index_reg),
        .wdata (sample_reg),
        .raddr (bucket_index_reg),
        .rdata (prev_rdata)
    );

    sfbd_ram #(.WIDTH(HW), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
        .clk   (clk),
        .we    (cmd.finish),
        .waddr (ptr_reg),
        .wdata ({flux_reg, thr_reg}),
        .raddr (walk_k_reg[HAW-1:0]),
        .rdata (hist_rdata)
    );

    assign hist_flux = hist_rdata[HW-1:THR_W];
    assign hist_thr  = hist_rdata[THR_W-1:0];

    always_comb
    begin
        unique case (cmd.div_op)
            DIV_FLUX:
            begin
                div_dividend = NW'(rise_sum_reg);
                div_divisor  = DVW'(count);
            end
            DIV_MEAN:
            begin
                div_dividend = total_reg;
                div_divisor  = DVW'(fill_reg);
            end
            DIV_BEAT:
            begin
                div_dividend = beat_sum_reg;
                div_divisor  = DVW'(beats_reg);
            end
            DIV_NORM:
            begin
                div_dividend = normal_sum_reg;
                div_divisor  = DVW'(normals_reg);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    sfbd_div #(.NW(NW), .DVW(DVW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // midpoint of the class averages once the history is full and mixed
    assign use_mid  = (fill_reg == HCW'(HISTORY_DEPTH)) && (beats_reg != '0)
                      && (normals_reg != '0);
    assign mid_sum  = {1'b0, beat_avg_reg} + {1'b0, normal_avg_reg};
    assign product  = mult_reg * mean_reg;
    // q4.4 times q16.0 shifted down by four always fits in 20 bits
    assign thr_calc = use_mid ? THR_W'(mid_sum[SB:1]) : product[SB+MULT_W-1:4];

    assign excess = ({{(THR_W-SB){1'b0}}, flux_reg} > thr_reg)
                    ? flux_reg - thr_reg[SB-1:0] : '0;
    assign beat   = ((excess != '0) && (flux_reg >= last_beat_reg)) ? flux_reg : '0;

    assign status.frame_result = last && prev_valid_reg;
    assign status.div_done     = div_done;
    assign status.walk_done    = (walk_k_reg >= fill_reg) && !walk_rdv_reg;
    assign status.out_free     = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RST;
            mult_reg         <= DEFAULT_MULT_RST;
            bucket_index_reg <= '0;
            rise_sum_reg     <= '0;
            prev_valid_reg   <= 1'b0;
            ptr_reg          <= '0;
            fill_reg         <= '0;
            last_beat_reg    <= '0;
            walk_k_reg       <= '0;
            walk_rdv_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.accumulate)
            begin
                if (last)
                begin
                    bucket_index_reg <= '0;
                    if (!prev_valid_reg)
                    begin
                        prev_valid_reg <= 1'b1;
                        rise_sum_reg   <= '0;
                    end
                    else if (sample_reg > prev_rdata)
                    begin
                        rise_sum_reg <= rise_sum_reg + RSW'(sample_reg - prev_rdata);
                    end
                end
                else
                begin
                    bucket_index_reg <= bucket_index_reg + IW'(1);
                    if (prev_valid_reg && (sample_reg > prev_rdata))
                    begin
                        rise_sum_reg <= rise_sum_reg + RSW'(sample_reg - prev_rdata);
                    end
                end
            end

            if (div_done && (cmd.div_op == DIV_FLUX))
            begin
                rise_sum_reg <= '0;
            end

            if (cmd.walk_clear)
            begin
                walk_k_reg   <= '0;
                walk_rdv_reg <= 1'b0;
            end
            else if (cmd.walk)
            begin
                if (walk_k_reg < fill_reg)
                begin
                    walk_k_reg   <= walk_k_reg + HCW'(1);
                    walk_rdv_reg <= 1'b1;
                end
                else
                begin
                    walk_rdv_reg <= 1'b0;
                end
            end

            if (cmd.finish)
            begin
                ptr_reg <= (ptr_reg == HAW'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + HAW'(1);
                if (fill_reg < HCW'(HISTORY_DEPTH))
                begin
                    fill_reg <= fill_reg + HCW'(1);
                end
                last_beat_reg <= beat;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                if (cfg_index == CFG_BUCKET_COUNT)
                begin
                    bucket_count_reg <= cfg_data[BCNT_W-1:0];
                    bucket_index_reg <= '0;
                    rise_sum_reg     <= '0;
                    prev_valid_reg   <= 1'b0;
                end
                else if (cfg_index == CFG_DEFAULT_MULT)
                begin
                    mult_reg <= cfg_data[MULT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= bucket_value;
        end

        if (cmd.walk_clear)
        begin
            total_reg      <= '0;
            beat_sum_reg   <= '0;
            normal_sum_reg <= '0;
            beats_reg      <= '0;
            normals_reg    <= '0;
        end
        else if (cmd.walk && walk_rdv_reg)
        begin
            total_reg <= total_reg + NW'(hist_flux);
            if ({{(THR_W-SB){1'b0}}, hist_flux} > hist_thr)
            begin
                beat_sum_reg <= beat_sum_reg + NW'(hist_flux);
                beats_reg    <= beats_reg + HCW'(1);
            end
            else
            begin
                normal_sum_reg <= normal_sum_reg + NW'(hist_flux);
                normals_reg    <= normals_reg + HCW'(1);
            end
        end

        if (div_done)
        begin
            unique case (cmd.div_op)
                DIV_FLUX: flux_reg <= div_quotient[SB-1:0];
                DIV_MEAN: mean_reg <= (fill_reg == '0) ? '0 : div_quotient[SB-1:0];
                DIV_BEAT: beat_avg_reg <= div_quotient[SB-1:0];
                DIV_NORM: normal_avg_reg <= div_quotient[SB-1:0];
                default:  flux_reg <= flux_reg;
            endcase
        end

        if (cmd.thresh)
        begin
            thr_reg <= thr_calc;
        end

        if (cmd.finish)
        begin
            flux_value      <= flux_reg;
            threshold_value <= thr_reg;
            excess_value    <= excess;
            beat_strength   <= beat;
            is_beat         <= (beat != '0);
        end
    end

    assign out_valid = out_valid_reg;
endmodule

FILE: test/spectral_flux_beat_detector_tb.sv
// self-checking testbench of the spectral flux beat detector
`timescale 1ns / 1ps
module spectral_flux_beat_detector_tb;
    import sfbd_pkg::*;

    localparam int MAX_BKT    = 512;
    localparam int HIST_DEPTH = 100;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [15:0] flux;
        logic [19:0] thr;
        logic [15:0] excess;
        logic [15:0] strength;
        logic        beat;
    } onset_t;

    class onset_scoreboard;
        logic [9:0]  bucket_cnt;
        logic [7:0]  mult;
        logic [15:0] prev_mag [MAX_BKT];
        logic [15:0] flux_hist [HIST_DEPTH];
        logic [19:0] thr_hist [HIST_DEPTH];
        int          wr_ptr;
        int          fill;
        int          bkt_idx;
        longint      rise_acc;
        bit          have_prev;
        logic [15:0] last_strength;
        onset_t      pending[$];
        int          errors;

        function void clear();
            bucket_cnt = BUCKET_COUNT_RST;
            mult = DEFAULT_MULT_RST;
            wr_ptr = 0;
            fill = 0;
            bkt_idx = 0;
            rise_acc = 0;
            have_prev = 0;
            last_strength = 0;
            errors = 0;
            pending.delete();
        endfunction

        function void note_config(logic [7:0] idx, logic [9:0] val);
            if (idx == CFG_BUCKET_COUNT)
            begin
                bucket_cnt = val;
                bkt_idx = 0;
                rise_acc = 0;
                have_prev = 0;
            end
            else if (idx == CFG_DEFAULT_MULT)
                mult = val[7:0];
        endfunction

        function longint adaptive_threshold();
            longint total, bsum, nsum, t;
            int nb, nn, mean;
            total = 0; bsum = 0; nsum = 0; nb = 0; nn = 0; mean = 0;
            for (int k = 0; k < fill; k++)
            begin
                total += flux_hist[k];
                if (flux_hist[k] > thr_hist[k])
                begin
                    bsum += flux_hist[k];
                    nb++;
                end
                else
                begin
                    nsum += flux_hist[k];
                    nn++;
                end
            end
            if (fill > 0)
                mean = int'(total / fill);
            if (fill >= HIST_DEPTH && nb > 0 && nn > 0)
                t = (bsum / nb + nsum / nn) >> 1;
            else
                t = (longint'(mult) * mean) >> 4;
            if (t > 20'hFFFFF)
                t = 20'hFFFFF;
            return t;
        endfunction

        function void note_bucket(logic [15:0] v);
            int cnt, idx;
            longint flux, thr, exc, str;
            onset_t o;
            cnt = bucket_cnt == 0 ? 1 : (bucket_cnt > MAX_BKT ? MAX_BKT : int'(bucket_cnt));
            idx = bkt_idx;
            if (have_prev && v > prev_mag[idx])
                rise_acc += v - prev_mag[idx];
            prev_mag[idx] = v;
            if (idx + 1 < cnt)
            begin
                bkt_idx = idx + 1;
                return;
            end
            bkt_idx = 0;
            if (!have_prev)
            begin
                have_prev = 1;
                rise_acc = 0;
                return;
            end
            flux = (rise_acc / cnt) & 16'hFFFF;
            rise_acc = 0;
            thr = adaptive_threshold();
            exc = flux > thr ? flux - thr : 0;
            str = exc > 0 ? flux : 0;
            if (str < last_strength)
                str = 0;
            flux_hist[wr_ptr] = 16'(flux);
            thr_hist[wr_ptr] = 20'(thr);
            wr_ptr = wr_ptr + 1 >= HIST_DEPTH ? 0 : wr_ptr + 1;
            if (fill < HIST_DEPTH)
                fill++;
            last_strength = 16'(str);
            o.flux = 16'(flux);
            o.thr = 20'(thr);
            o.excess = 16'(exc);
            o.strength = 16'(str);
            o.beat = (str != 0);
            pending.push_back(o);
        endfunction

        function void check_onset(onset_t got);
            onset_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat flux=%0d", got.flux);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.flux !== e.flux)
            begin
                $error("flux_value expected %0d actual %0d", e.flux, got.flux);
                errors++;
            end
            if (got.thr !== e.thr)
            begin
                $error("threshold_value expected %0d actual %0d", e.thr, got.thr);
                errors++;
            end
            if (got.excess !== e.excess)
            begin
                $error("excess_value expected %0d actual %0d", e.excess, got.excess);
                errors++;
            end
            if (got.strength !== e.strength)
            begin
                $error("beat_strength expected %0d actual %0d", e.strength, got.strength);
                errors++;
            end
            if (got.beat !== e.beat)
            begin
                $error("is_beat expected %0d actual %0d", e.beat, got.beat);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    sfbd_in_if  bucket_in ();
    sfbd_out_if result_out ();
    sfbd_cfg_if cfg ();

    spectral_flux_beat_detector uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .bucket_in  (bucket_in),
        .result_out (result_out),
        .cfg        (cfg)
    );

    onset_scoreboard sb;
    int  cycles;
    bit  long_hold;
    bit  hold_done;
    bit  stall_on;

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stall pattern, plus one long hold-off on request
    initial
    begin
        int hold;
        result_out.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_done)
            begin
                result_out.ready <= 0;
                for (hold = 0; hold < 3000; hold++)
                    @(posedge clk);
                hold_done = 1;
            end
            else if (stall_on)
                result_out.ready <= ($urandom_range(0, 3) != 0);
            else
                result_out.ready <= 1;
        end
    end

    always @(posedge clk)
        if (rst_n && result_out.valid && result_out.ready)
            sb.check_onset({result_out.flux_value, result_out.threshold_value,
                            result_out.excess_value, result_out.beat_strength,
                            result_out.is_beat});

    int burst_left;

    task automatic send_bucket(logic [15:0] v);
        if (burst_left == 0)
        begin
            int gap;
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                bucket_in.valid <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        bucket_in.valid <= 1;
        bucket_in.bucket_value <= v;
        do
            @(posedge clk);
        while (!bucket_in.ready);
        sb.note_bucket(v);
    endtask

    task automatic drain();
        bucket_in.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        // the frame end pass has ended once the last result is out; this only adds idle time
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [9:0] val);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 0;
        sb.note_config(idx, val);
        @(posedge clk);
    endtask

    task automatic send_frames(int frames, int cnt, int mode);
        for (int f = 0; f < frames; f++)
            for (int b = 0; b < cnt; b++)
                case (mode)
                    0: send_bucket(16'($urandom_range(0, 65535)));
                    1: send_bucket((f % 4 == 0) ? 16'hFFFF : 16'($urandom_range(0, 2000)));
                    2: send_bucket(f[0] ? 16'hFFFF : 16'h0000);
                    default: send_bucket(16'($urandom_range(0, 300)
                                             * ((f % 7 == 3) ? 200 : 1)));
                endcase
    endtask

    initial
    begin
        int remaining;
        sb = new();
        sb.clear();
        long_hold = 0;
        stall_on = 0;
        burst_left = 0;
        bucket_in.valid = 0;
        bucket_in.bucket_value = 0;
        cfg.valid = 0;
        cfg.index = 0;
        cfg.data = 0;
        rst_n = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes at reset settings, then tiny frames
        send_frames(3, 64, 2);
        drain();
        write_reg(CFG_BUCKET_COUNT, 10'd1);
        write_reg(CFG_DEFAULT_MULT, 10'd0);
        send_bucket(16'h0000);
        send_bucket(16'hFFFF);
        send_bucket(16'h0000);
        send_bucket(16'h5555);
        send_bucket(16'hAAAA);
        drain();
        write_reg(CFG_DEFAULT_MULT, 10'd255);
        write_reg(8'd7, 10'h3FF);
        write_reg(CFG_BUCKET_COUNT, 10'd0);
        send_bucket(16'h0001);
        send_bucket(16'hFFFE);
        send_bucket(16'h8000);
        drain();

        // random, with history wrapping and full-history threshold
        stall_on = 1;
        write_reg(CFG_BUCKET_COUNT, 10'd3);
        write_reg(CFG_DEFAULT_MULT, 10'd24);
        send_frames(130, 3, 1);
        long_hold = 1;
        send_frames(60, 3, 3);
        drain();
        write_reg(CFG_DEFAULT_MULT, 10'($urandom_range(0, 255)));
        send_frames(60, 2, 0);
        drain();
        write_reg(CFG_BUCKET_COUNT, 10'h3FF);
        send_frames(2, 512, 0);
        drain();
        stall_on = 0;
        remaining = 1950 - 1914;
        write_reg(CFG_BUCKET_COUNT, 10'd5);
        send_frames(remaining / 5, 5, 1);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: sim.f
hdl/sfbd_pkg.sv
hdl/sfbd_intf.sv
hdl/sfbd_ram.sv
hdl/sfbd_div.sv
hdl/sfbd_ctrl.sv
hdl/sfbd_dp.sv
hdl/spectral_flux_beat_detector.sv
test/spectral_flux_beat_detector_tb.sv
